@@ design/tlq_pkg.sv @@
// Shared types, constants and sequencer states of the delta-list timer queue.
`default_nettype none
package tlq_pkg;

   localparam int unsigned DELTA_W             = 16;
   localparam int unsigned PROC_W              = 8;
   localparam int unsigned TPS_W               = 8;
   localparam int unsigned KIND_W              = 2;
   localparam int unsigned MAX_WAKE            = 16;
   localparam int unsigned WAKE_CNT_W          = $clog2(MAX_WAKE + 1);
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   localparam logic [TPS_W-1:0] TPS_RESET = 8'd120;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [KIND_W-1:0] KIND_WOKEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

   typedef struct packed {
      logic [DELTA_W-1:0] delta;
      logic [PROC_W-1:0]  proc;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_DEC,
      ST_POP,
      ST_LOOK,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

@@ design/delta_list_timer_queue.sv @@
// Top level of the delta-list timer queue: rate register, sequencer, store, subtractor.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  command, delay_seconds, proc_id
//   rsp_     out        rsp_valid/rsp_stall  kind, woken_id, last
//   csr_     in         csr_valid/csr_ready  ticks_per_second
//
// A tick that does not complete a second is handled in idle. An insert walks the list,
// moves each later entry up by a read and a write, places its entry, then gives one
// result beat (a rejected one only that beat). A second step decrements the head and
// pops each woken process, one beat each; the single read port of the store paces this.
// Reset is synchronous and empties the queue; entries are not cleared.
// The request side stalls until the sequencer is idle again, after any last result beat.
`default_nettype none
module delta_list_timer_queue #(
   parameter int unsigned QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_command,
   input  wire logic [tlq_pkg::DELTA_W-1:0]   req_delay_seconds,
   input  wire logic [tlq_pkg::PROC_W-1:0]    req_proc_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tlq_pkg::KIND_W-1:0]         rsp_kind,
   output logic [tlq_pkg::PROC_W-1:0]         rsp_woken_id,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlq_pkg::TPS_W-1:0]     csr_ticks_per_second
);
   import tlq_pkg::*;

   localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);

   logic [TPS_W-1:0]   tps_ff, tps_in;
   logic               mem_wr_en;
   logic [AddrW-1:0]   mem_wr_addr;
   entry_type          mem_wr_data;
   logic [AddrW-1:0]   mem_rd_addr;
   entry_type          mem_rd_data;
   logic [DELTA_W-1:0] alu_a;
   logic [DELTA_W-1:0] alu_b;
   logic [DELTA_W-1:0] alu_diff;
   logic               alu_ge;

   assign csr_ready = 1'b1;
   assign tps_in    = (csr_valid && csr_ready) ? csr_ticks_per_second : tps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else begin
         tps_ff <= tps_in;
      end
   end

   tlq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .ticks_per_second  (tps_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_delay_seconds (req_delay_seconds),
      .req_proc_id       (req_proc_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_woken_id      (rsp_woken_id),
      .rsp_last          (rsp_last),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .alu_a             (alu_a),
      .alu_b             (alu_b),
      .alu_diff          (alu_diff),
      .alu_ge            (alu_ge)
   );

   tlq_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   tlq_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .a_ge_b (alu_ge)
   );

endmodule
`default_nettype wire

@@ design/tlq_mem.sv @@
// Entry store of the timer queue: one write port, one registered read port.
`default_nettype none
module tlq_mem #(
   parameter int unsigned QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int unsigned AddrW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AddrW-1:0]   wr_addr,
   input  wire tlq_pkg::entry_type wr_data,
   input  wire logic [AddrW-1:0]   rd_addr,
   output tlq_pkg::entry_type      rd_data_ff
);
   import tlq_pkg::*;

   entry_type mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/tlq_alu.sv @@
// Shared subtract and compare unit for delay walk, delta fix-up and head decrement.
`default_nettype none
module tlq_alu (
   input  wire logic [tlq_pkg::DELTA_W-1:0] op_a,
   input  wire logic [tlq_pkg::DELTA_W-1:0] op_b,
   output logic [tlq_pkg::DELTA_W-1:0]      diff,
   output logic                             a_ge_b
);
   import tlq_pkg::*;

   logic [DELTA_W:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = wide_diff[DELTA_W-1:0];
   assign a_ge_b    = ~wide_diff[DELTA_W];

endmodule
`default_nettype wire

@@ design/tlq_ctrl.sv @@
// Sequencer of the timer queue: prescaler, insert walk and shift, head wake pops.
`default_nettype none
module tlq_ctrl #(
   parameter int unsigned QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int unsigned AddrW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [tlq_pkg::TPS_W-1:0]     ticks_per_second,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_command,
   input  wire logic [tlq_pkg::DELTA_W-1:0]   req_delay_seconds,
   input  wire logic [tlq_pkg::PROC_W-1:0]    req_proc_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tlq_pkg::KIND_W-1:0]         rsp_kind,
   output logic [tlq_pkg::PROC_W-1:0]         rsp_woken_id,
   output logic                               rsp_last,
   output logic                               mem_wr_en,
   output logic [AddrW-1:0]                   mem_wr_addr,
   output tlq_pkg::entry_type                 mem_wr_data,
   output logic [AddrW-1:0]                   mem_rd_addr,
   input  wire tlq_pkg::entry_type            mem_rd_data,
   output logic [tlq_pkg::DELTA_W-1:0]        alu_a,
   output logic [tlq_pkg::DELTA_W-1:0]        alu_b,
   input  wire logic [tlq_pkg::DELTA_W-1:0]   alu_diff,
   input  wire logic                          alu_ge
);
   import tlq_pkg::*;

   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   state_type             state_ff, state_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [AddrW-1:0]      head_ff, head_in;
   logic [AddrW-1:0]      pos_ff, pos_in;
   logic [AddrW-1:0]      idx_ff, idx_in;
   logic [TPS_W-1:0]      presc_ff, presc_in;
   logic [WAKE_CNT_W-1:0] wake_n_ff, wake_n_in;
   logic [DELTA_W-1:0]    delay_ff, delay_in;
   logic [PROC_W-1:0]     id_ff, id_in;
   logic [PROC_W-1:0]     cur_proc_ff, cur_proc_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [PROC_W-1:0]     out_id_ff, out_id_in;
   logic                  last_ff, last_in;
   logic [TPS_W:0]        presc_next;

   function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                              input logic [AddrW-1:0] ofs);
      logic [AddrW:0] sum;
      sum = {1'b0, head} + {1'b0, ofs};
      if (sum >= (AddrW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AddrW+1)'(QUEUE_DEPTH);
      end
      return sum[AddrW-1:0];
   endfunction

   assign presc_next   = {1'b0, presc_ff} + (TPS_W+1)'(1);
   assign rsp_kind     = kind_ff;
   assign rsp_woken_id = out_id_ff;
   assign rsp_last     = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         presc_ff  <= '0;
         wake_n_ff <= '0;
         pos_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         presc_ff  <= presc_in;
         wake_n_ff <= wake_n_in;
         pos_ff    <= pos_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff    <= delay_in;
      id_ff       <= id_in;
      cur_proc_ff <= cur_proc_in;
      kind_ff     <= kind_in;
      out_id_ff   <= out_id_in;
      last_ff     <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      presc_in    = presc_ff;
      wake_n_in   = wake_n_ff;
      delay_in    = delay_ff;
      id_in       = id_ff;
      cur_proc_in = cur_proc_ff;
      kind_in     = kind_ff;
      out_id_in   = out_id_ff;
      last_in     = last_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = head_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = head_ff;
      alu_a       = delay_ff;
      alu_b       = mem_rd_data.delta;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               id_in     = req_proc_id;
               delay_in  = (req_delay_seconds == '0) ? DELTA_W'(1) : req_delay_seconds;
               pos_in    = '0;
               wake_n_in = '0;
               if (req_command == CMD_INSERT) begin
                  if (count_ff == CntW'(QUEUE_DEPTH)) begin
                     kind_in   = KIND_FULL;
                     out_id_in = req_proc_id;
                     last_in   = 1'b1;
                     state_in  = ST_OUT;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else if (presc_next < {1'b0, ticks_per_second}) begin
                  presc_in = presc_next[TPS_W-1:0];
               end else begin
                  presc_in = '0;
                  if (count_ff != '0) begin
                     state_in = ST_DEC;
                  end
               end
            end
         end
         ST_WALK: begin
            alu_a = delay_ff;
            alu_b = mem_rd_data.delta;
            if ((CntW'(pos_ff) < count_ff) && alu_ge) begin
               delay_in    = alu_diff;
               pos_in      = pos_ff + AddrW'(1);
               mem_rd_addr = phys(head_ff, pos_ff + AddrW'(1));
            end else begin
               idx_in   = count_ff[AddrW-1:0];
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_ff > pos_ff) begin
               mem_rd_addr = phys(head_ff, idx_ff - AddrW'(1));
               state_in    = ST_SHIFT_WR;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_SHIFT_WR: begin
            alu_a       = mem_rd_data.delta;
            alu_b       = delay_ff;
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, idx_ff);
            mem_wr_data = mem_rd_data;
            if (idx_ff == pos_ff + AddrW'(1)) begin
               mem_wr_data.delta = alu_diff;
            end
            idx_in   = idx_ff - AddrW'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_PLACE: begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = phys(head_ff, pos_ff);
            mem_wr_data.delta = delay_ff;
            mem_wr_data.proc  = id_ff;
            count_in          = count_ff + CntW'(1);
            kind_in           = KIND_ACCEPT;
            out_id_in         = id_ff;
            last_in           = 1'b1;
            state_in          = ST_OUT;
         end
         ST_DEC: begin
            alu_a       = mem_rd_data.delta;
            alu_b       = DELTA_W'(1);
            cur_proc_in = mem_rd_data.proc;
            if (alu_ge) begin
               mem_wr_en         = 1'b1;
               mem_wr_addr       = head_ff;
               mem_wr_data.delta = alu_diff;
            end
            if (!alu_ge || alu_diff == '0) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            mem_rd_addr = phys(head_ff, AddrW'(1));
            state_in    = ST_LOOK;
         end
         ST_LOOK: begin
            kind_in     = KIND_WOKEN;
            out_id_in   = cur_proc_ff;
            last_in     = (count_ff == CntW'(1)) || (mem_rd_data.delta != '0)
                          || (wake_n_ff == WAKE_CNT_W'(MAX_WAKE - 1));
            cur_proc_in = mem_rd_data.proc;
            head_in     = phys(head_ff, AddrW'(1));
            count_in    = count_ff - CntW'(1);
            wake_n_in   = wake_n_ff + WAKE_CNT_W'(1);
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = last_ff ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ test/delta_list_timer_queue_tb.sv @@
// Self-checking bench for the delta-list timer queue: directed and random beats against a model.
`timescale 1ns / 100ps
module delta_list_timer_queue_tb;
   import tlq_pkg::*;

   localparam int unsigned SLOTS         = QUEUE_DEPTH_DEFAULT;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned DRAIN_LIMIT   = 50000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PROC_W-1:0] id;
      logic              last;
   } notice_type;

   logic                clock;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic                req_stall;
   logic                req_command          = CMD_TICK;
   logic [DELTA_W-1:0]  req_delay_seconds    = '0;
   logic [PROC_W-1:0]   req_proc_id          = '0;
   logic                rsp_valid;
   logic                rsp_stall            = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [PROC_W-1:0]   rsp_woken_id;
   logic                rsp_last;
   logic                csr_valid            = 1'b0;
   logic                csr_ready;
   logic [TPS_W-1:0]    csr_ticks_per_second = TPS_RESET;

   logic [DELTA_W-1:0]  slot_delta [SLOTS];
   logic [PROC_W-1:0]   slot_proc [SLOTS];
   int unsigned         slot_count = 0;
   int unsigned         prescale   = 0;
   logic [TPS_W-1:0]    model_rate = TPS_RESET;

   notice_type          notice_fifo [$];
   notice_type          arrived_want;
   int unsigned         fail_count = 0;
   int unsigned         gap_mode   = 1;
   int unsigned         stall_hold = 0;
   int unsigned         stall_mode = 0;
   int unsigned         mode_left  = 0;

   delta_list_timer_queue dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_delay_seconds    (req_delay_seconds),
      .req_proc_id          (req_proc_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_woken_id         (rsp_woken_id),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ticks_per_second (csr_ticks_per_second)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic forecast_notices(input logic cmd, input logic [DELTA_W-1:0] delay,
                                   input logic [PROC_W-1:0] id);
      int unsigned       pos;
      int unsigned       remain;
      int unsigned       woken;
      logic [PROC_W-1:0] head_id;
      logic              more;
      if (cmd == CMD_INSERT) begin
         if (slot_count >= SLOTS) begin
            notice_fifo.push_back('{KIND_FULL, id, 1'b1});
            return;
         end
         remain = (delay == 0) ? 1 : delay;
         pos = 0;
         while (pos < slot_count && remain >= slot_delta[pos]) begin
            remain -= slot_delta[pos];
            pos++;
         end
         for (int unsigned i = slot_count; i > pos; i--) begin
            slot_delta[i] = slot_delta[i-1];
            slot_proc[i]  = slot_proc[i-1];
         end
         slot_delta[pos] = DELTA_W'(remain);
         slot_proc[pos]  = id;
         slot_count++;
         if (pos + 1 < slot_count)
            slot_delta[pos+1] = slot_delta[pos+1] - DELTA_W'(remain);
         notice_fifo.push_back('{KIND_ACCEPT, id, 1'b1});
         return;
      end
      prescale++;
      if (prescale < model_rate)
         return;
      prescale = 0;
      if (slot_count == 0)
         return;
      if (slot_delta[0] != 0)
         slot_delta[0]--;
      woken = 0;
      more  = (slot_delta[0] == 0);
      while (more) begin
         head_id = slot_proc[0];
         for (int unsigned i = 1; i < slot_count; i++) begin
            slot_delta[i-1] = slot_delta[i];
            slot_proc[i-1]  = slot_proc[i];
         end
         slot_count--;
         woken++;
         more = (slot_count != 0) && (slot_delta[0] == 0) && (woken < MAX_WAKE);
         notice_fifo.push_back('{KIND_WOKEN, head_id, !more});
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (notice_fifo.size() == 0) begin
            $display("%0t: unexpected beat kind=%0d id=%0d last=%0d",
                     $time, rsp_kind, rsp_woken_id, rsp_last);
            fail_count++;
         end else begin
            arrived_want = notice_fifo.pop_front();
            if (rsp_kind !== arrived_want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, arrived_want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_woken_id !== arrived_want.id) begin
               $display("%0t: woken_id expected %0d actual %0d",
                        $time, arrived_want.id, rsp_woken_id);
               fail_count++;
            end
            if (rsp_last !== arrived_want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, arrived_want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 200);
      end else
         mode_left--;
      if (stall_hold != 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 25);
            default: begin
               if ($urandom_range(0, 99) < 8) begin
                  stall_hold = $urandom_range(5, 30);
                  rsp_stall <= 1'b1;
               end else
                  rsp_stall <= ($urandom_range(0, 99) < 40);
            end
         endcase
      end
   end

   task automatic send_beat(input logic cmd, input logic [DELTA_W-1:0] delay,
                            input logic [PROC_W-1:0] id);
      int unsigned gap;
      int unsigned r;
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_delay_seconds <= delay;
      req_proc_id       <= id;
      do @(posedge clock); while (req_stall);
      forecast_notices(cmd, delay, id);
      r = $urandom_range(0, 99);
      if (gap_mode == 0 || r < 60)
         gap = 0;
      else if (r < 92)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (notice_fifo.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (notice_fifo.size() != 0) begin
         $display("%0t: %0d result beats never arrived", $time, notice_fifo.size());
         fail_count++;
         notice_fifo.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_tick_rate(input logic [TPS_W-1:0] rate);
      wait_idle();
      csr_valid            <= 1'b1;
      csr_ticks_per_second <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      model_rate = rate;
   endtask

   task automatic test_full_list_burst();
      set_tick_rate(8'd0);
      for (int unsigned i = 0; i < SLOTS; i++)
         send_beat(CMD_INSERT, DELTA_W'(i % 2), PROC_W'(i * 17));
      send_beat(CMD_INSERT, 16'd3, 8'h5A);
      send_beat(CMD_TICK, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_empty_and_extremes();
      send_beat(CMD_TICK, 16'h0000, 8'h00);
      send_beat(CMD_INSERT, 16'hFFFF, 8'h81);
      send_beat(CMD_INSERT, 16'd2, 8'h42);
      send_beat(CMD_TICK, 16'h1234, 8'h00);
      send_beat(CMD_TICK, 16'h0000, 8'hC3);
   endtask

   task automatic test_random_phase(input logic [TPS_W-1:0] rate, input int unsigned count);
      int unsigned        r;
      logic [DELTA_W-1:0] delay;
      set_tick_rate(rate);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 25 == 0)
            gap_mode = $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 3)
            wait_idle();
         r = $urandom_range(0, 99);
         if (r < 70)
            delay = DELTA_W'($urandom_range(0, 4));
         else if (r < 98)
            delay = DELTA_W'($urandom_range(5, 30));
         else
            delay = DELTA_W'($urandom);
         send_beat(($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_TICK, delay,
                   PROC_W'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_full_list_burst();
      test_empty_and_extremes();
      test_random_phase(8'd1, 60);
      test_random_phase(8'd0, 60);
      test_random_phase(8'd255, 50);
      test_random_phase(8'd3, 60);
      test_random_phase(TPS_W'($urandom_range(2, 16)), 60);
      test_random_phase(8'd1, 60);
      wait_idle();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
